[design/scps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scps_pkg
// Shared types and constants for the servo command parser with slew output.
// ----------------------------------------------------------------------------
package scps_pkg;

    // Opcodes of the command channel
    localparam logic [1:0] OP_RX_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_HOME_ONE = 2'd2;
    localparam logic [1:0] OP_HOME_TWO = 2'd3;

    // Frame characters
    localparam logic [7:0] CH_START = 8'h73; // 's'
    localparam logic [7:0] CH_END   = 8'h65; // 'e'
    localparam logic [7:0] CH_COMMA = 8'h2c; // ','
    localparam logic [7:0] CH_MINUS = 8'h2d; // '-'
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Number handling
    localparam logic [13:0] ACC_MAX   = 14'd9999;
    localparam logic [13:0] ONE_LIMIT = 14'd150;
    localparam logic [13:0] TWO_LIMIT = 14'd90;
    localparam logic [11:0] HOME_ONE  = 12'd1600;
    localparam logic [11:0] HOME_TWO  = 12'd1500;
    localparam logic [11:0] ONE_MAX   = 12'd2500;
    localparam logic [11:0] ONE_STEP  = 12'd6;
    localparam logic [11:0] TWO_STEP  = 12'd10;

    // Compare reset values
    localparam logic [7:0] CMP_ONE_RST = 8'd100;
    localparam logic [7:0] CMP_TWO_RST = 8'd94;

    // Slew dead band, in sixteenths of a count
    localparam logic [12:0] SLEW_BAND = 13'd16;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO,
        PH_END
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0] pwm_one;
        logic [7:0] pwm_two;
    } t_pwm;

    typedef struct packed {
        logic byte_valid;
        logic home_one;
        logic home_two;
    } t_parse_ctl;

    typedef struct packed {
        logic [11:0] target_one;
        logic [11:0] target_two;
    } t_targets;

endpackage

[design/scps_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scps_parser
// Frame parser: decodes the two numbers of an 's...e' frame into targets.
// ----------------------------------------------------------------------------
module scps_parser import scps_pkg::*; #(
    parameter int FRAME_CHARS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_parse_ctl i_ctl,
    input  logic [7:0] i_rx_byte,
    output t_targets   o_targets
);

    localparam int CW = $clog2(FRAME_CHARS);

    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_chars, n_chars;
    logic [13:0]     r_acc_one, n_acc_one;
    logic [13:0]     r_acc_two, n_acc_two;
    logic            r_neg_pending, n_neg_pending;
    logic            r_neg_first, n_neg_first;
    logic [11:0]     r_tgt_one, n_tgt_one;
    logic [11:0]     r_tgt_two, n_tgt_two;
    logic            last_char;
    logic [13:0]     two_mag;

    // acc*10 plus digit, saturating
    function automatic logic [13:0] f_acc(input logic [13:0] acc, input logic [7:0] ch);
        logic [16:0] prod;
        logic [16:0] sum;
        prod = 17'(acc) * 17'd10;
        sum  = prod + ((ch >= CH_ZERO && ch <= CH_NINE) ? 17'(ch - CH_ZERO) : 17'd0);
        return (sum > 17'(ACC_MAX)) ? ACC_MAX : sum[13:0];
    endfunction

    // true when the frame ends up in the after-'e' phase with this byte
    function automatic logic f_end_hit(input t_phase ph, input logic [7:0] ch);
        return (ph == PH_END) || (ph == PH_TWO && ch == CH_END);
    endfunction

    assign last_char = (r_chars == CW'(FRAME_CHARS - 1));
    assign two_mag   = (r_acc_two > TWO_LIMIT) ? TWO_LIMIT : r_acc_two;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_ctl.byte_valid) begin
            unique case (r_phase)
                PH_IDLE: if (i_rx_byte == CH_START) n_phase = PH_ONE;
                PH_ONE:  if (i_rx_byte == CH_COMMA) n_phase = PH_TWO;
                PH_TWO:  if (i_rx_byte == CH_END)   n_phase = PH_END;
                default: n_phase = r_phase;
            endcase
            if (r_phase != PH_IDLE && last_char) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // datapath
    always_comb begin
        n_chars       = r_chars;
        n_acc_one     = r_acc_one;
        n_acc_two     = r_acc_two;
        n_neg_pending = r_neg_pending;
        n_neg_first   = r_neg_first;
        n_tgt_one     = r_tgt_one;
        n_tgt_two     = r_tgt_two;
        if (i_ctl.byte_valid) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == CH_START) begin
                        n_chars       = '0;
                        n_acc_one     = '0;
                        n_acc_two     = '0;
                        n_neg_pending = 1'b0;
                        n_neg_first   = 1'b0;
                    end
                end
                PH_ONE: begin
                    if (i_rx_byte == CH_COMMA) begin
                        n_neg_first   = r_neg_pending;
                        n_neg_pending = 1'b0;
                    end else begin
                        n_acc_one = f_acc(r_acc_one, i_rx_byte);
                        if (i_rx_byte == CH_MINUS) n_neg_pending = 1'b1;
                    end
                end
                PH_TWO: begin
                    if (i_rx_byte != CH_END) begin
                        n_acc_two = f_acc(r_acc_two, i_rx_byte);
                        if (i_rx_byte == CH_MINUS) n_neg_pending = 1'b1;
                    end
                end
                default: ;
            endcase
            if (r_phase != PH_IDLE) begin
                if (last_char) begin
                    // frame complete: the 'e' never changes the numbers
                    if (f_end_hit(r_phase, i_rx_byte)) begin
                        if (!r_neg_first || r_acc_one == '0) begin
                            n_tgt_one = (r_acc_one > ONE_LIMIT) ? ONE_MAX
                                      : HOME_ONE + 12'(r_acc_one[7:0]) * ONE_STEP;
                        end
                        n_tgt_two = r_neg_pending
                                  ? HOME_TWO - 12'(two_mag[6:0]) * TWO_STEP
                                  : HOME_TWO + 12'(two_mag[6:0]) * TWO_STEP;
                    end
                    n_chars       = '0;
                    n_acc_one     = '0;
                    n_acc_two     = '0;
                    n_neg_pending = 1'b0;
                    n_neg_first   = 1'b0;
                end else begin
                    n_chars = r_chars + CW'(1);
                end
            end
        end
        if (i_ctl.home_one) n_tgt_one = HOME_ONE;
        if (i_ctl.home_two) n_tgt_two = HOME_TWO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_chars       <= '0;
            r_acc_one     <= '0;
            r_acc_two     <= '0;
            r_neg_pending <= 1'b0;
            r_neg_first   <= 1'b0;
            r_tgt_one     <= HOME_ONE;
            r_tgt_two     <= HOME_TWO;
        end else begin
            r_phase       <= n_phase;
            r_chars       <= n_chars;
            r_acc_one     <= n_acc_one;
            r_acc_two     <= n_acc_two;
            r_neg_pending <= n_neg_pending;
            r_neg_first   <= n_neg_first;
            r_tgt_one     <= n_tgt_one;
            r_tgt_two     <= n_tgt_two;
        end
    end

    assign o_targets.target_one = r_tgt_one;
    assign o_targets.target_two = r_tgt_two;

endmodule

[design/scps_slew.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scps_slew
// Slew limiter: per tick, steps each compare value one count toward target/16 unless within the dead band.
// ----------------------------------------------------------------------------
module scps_slew import scps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tick,
    input  t_targets i_targets,
    output t_pwm     o_next
);

    logic [7:0] r_cmp_one, n_cmp_one;
    logic [7:0] r_cmp_two, n_cmp_two;

    // one step toward tgt when |16*cmp - tgt| > 16
    function automatic logic [7:0] f_step(input logic [7:0] cmp, input logic [11:0] tgt);
        logic [12:0] c16;
        logic [12:0] t13;
        logic [7:0]  res;
        c16 = {1'b0, cmp, 4'b0000};
        t13 = {1'b0, tgt};
        res = cmp;
        if (c16 > t13 + SLEW_BAND)      res = cmp - 8'd1;
        else if (t13 > c16 + SLEW_BAND) res = cmp + 8'd1;
        return res;
    endfunction

    always_comb begin
        n_cmp_one = f_step(r_cmp_one, i_targets.target_one);
        n_cmp_two = f_step(r_cmp_two, i_targets.target_two);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_one <= CMP_ONE_RST;
            r_cmp_two <= CMP_TWO_RST;
        end else if (i_tick) begin
            r_cmp_one <= n_cmp_one;
            r_cmp_two <= n_cmp_two;
        end
    end

    assign o_next.pwm_one = n_cmp_one;
    assign o_next.pwm_two = n_cmp_two;

endmodule

[design/servo_command_parser_slew.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_parser_slew
// Servo command parser with slew-limited compare outputs (top level).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one command
//   per transaction: a received byte, a timer tick, or a home event for one
//   of the servos. Only a tick produces a result transaction on the output
//   channel (o_out_valid / i_out_ready / o_out_data), holding both compare
//   values after that tick's slew step.
//   Order: an accepted command lands in the input register and is executed
//   from there, a tick only once the output register can take its result;
//   a tick's result is then registered in the output register.
//   Throughput: one command per cycle, limited only by the output register
//   when a tick's result is not yet taken.
//   Stall: while the output register holds an untaken result, a tick in the
//   input register waits and input is held off; bytes and home events in the
//   input register still go through.
//   Reset (synchronous, active low): parser idle, targets at home, compare
//   values at their home counts, both registers empty.
// ----------------------------------------------------------------------------
module servo_command_parser_slew import scps_pkg::*; #(
    parameter int FRAME_CHARS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_cmd i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_pwm o_out_data
);

    // input register
    logic r_in_valid;
    t_cmd r_in;

    // output register
    logic r_out_valid;
    t_pwm r_out;

    logic       is_tick;
    logic       advance;
    t_parse_ctl ctl;
    t_targets   targets;
    t_pwm       slew_next;

    assign is_tick = (r_in.opcode == OP_TICK);

    // a tick moves on only when the output register can take its result
    assign advance    = r_in_valid && (!is_tick || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign ctl.byte_valid = advance && (r_in.opcode == OP_RX_BYTE);
    assign ctl.home_one   = advance && (r_in.opcode == OP_HOME_ONE);
    assign ctl.home_two   = advance && (r_in.opcode == OP_HOME_TWO);

    scps_parser #(
        .FRAME_CHARS (FRAME_CHARS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_rx_byte (r_in.rx_byte),
        .o_targets (targets)
    );

    scps_slew u_slew (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (advance && is_tick),
        .i_targets (targets),
        .o_next    (slew_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_tick) begin
            r_out <= slew_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[bench/servo_command_parser_slew_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_parser_slew_tb
// Self-checking bench for the servo command parser with slew output.
// ----------------------------------------------------------------------------
// A backlog of commands (bytes, ticks, home events) is built up front: a short
// directed run, then random traffic of framed commands with random
// content, plus tick runs, home events and noise. A clocked driver feeds the
// backlog with random gaps. A clocked monitor takes results with random
// stalls. Each accepted command goes through a local model of the parser and
// slew logic; every tick queues the compare pair it must produce, and the
// monitor checks results against that queue in order.
// ----------------------------------------------------------------------------
module servo_command_parser_slew_tb;
    import scps_pkg::*;

    localparam int FRAME_LEN   = 8;
    localparam int ITEM_TARGET = 1800;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        t_cmd cmd;
        int   gap;    // idle cycles before this transaction is offered
        bit   hold;   // wait for all outstanding results before offering it
    } t_cmd_slot;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    t_cmd in_data   = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_pwm o_out_data;

    t_cmd_slot cmd_backlog[$];
    t_pwm      pwm_due[$];     // compare pairs owed by accepted ticks

    // Local copy of the parser and slew state
    t_phase      phase;
    logic [3:0]  n_chars;
    logic [13:0] acc_one;
    logic [13:0] acc_two;
    bit          neg_cur;
    bit          neg_one;
    logic [11:0] tgt_one;
    logic [11:0] tgt_two;
    logic [7:0]  cmp_one;
    logic [7:0]  cmp_two;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_applied  = 0;
    int n_frames   = 0;
    int n_queued   = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;

    servo_command_parser_slew #(
        .FRAME_CHARS (FRAME_LEN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Generous ceiling: worst case is roughly 1900 transactions, each with the
    // longest gap and the longest result stall.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------
    function automatic void clear_frame();
        n_chars = '0;
        acc_one = '0;
        acc_two = '0;
        neg_cur = 1'b0;
        neg_one = 1'b0;
    endfunction

    // Decimal shift-in with saturation; non-digits only scale.
    function automatic logic [13:0] acc_push(logic [13:0] acc, logic [7:0] ch);
        int v;
        v = int'(acc) * 10;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            v += int'(ch) - int'(CH_ZERO);
        end
        return (v > int'(ACC_MAX)) ? ACC_MAX : 14'(v);
    endfunction

    // One count toward target/16, only outside the dead band.
    function automatic logic [7:0] slew_toward(logic [7:0] cmp, logic [11:0] tgt);
        int c16;
        int delta;
        c16   = int'(cmp) * 16;
        delta = (c16 > int'(tgt)) ? c16 - int'(tgt) : int'(tgt) - c16;
        if (delta > int'(SLEW_BAND)) begin
            return (c16 < int'(tgt)) ? cmp + 8'd1 : cmp - 8'd1;
        end
        return cmp;
    endfunction

    function automatic void servo_step(t_cmd c);
        t_pwm pair;
        int   mag;
        case (c.opcode)
            OP_RX_BYTE: begin
                if (phase == PH_IDLE) begin
                    if (c.rx_byte == CH_START) begin
                        phase = PH_ONE;
                        clear_frame();
                    end
                end else begin
                    if (phase == PH_ONE) begin
                        if (c.rx_byte == CH_COMMA) begin
                            neg_one = neg_cur;
                            neg_cur = 1'b0;
                            phase   = PH_TWO;
                        end else begin
                            if (c.rx_byte == CH_MINUS) neg_cur = 1'b1;
                            acc_one = acc_push(acc_one, c.rx_byte);
                        end
                    end else if (phase == PH_TWO) begin
                        if (c.rx_byte == CH_END) begin
                            phase = PH_END;
                        end else begin
                            if (c.rx_byte == CH_MINUS) neg_cur = 1'b1;
                            acc_two = acc_push(acc_two, c.rx_byte);
                        end
                    end
                    n_chars = n_chars + 4'd1;
                    if (int'(n_chars) >= FRAME_LEN) begin
                        if (phase == PH_END) begin
                            // negative nonzero first number keeps the old target
                            if (!neg_one || acc_one == '0) begin
                                if (acc_one > ONE_LIMIT) begin
                                    tgt_one = ONE_MAX;
                                end else begin
                                    tgt_one = 12'(int'(HOME_ONE) + int'(ONE_STEP) * int'(acc_one));
                                end
                            end
                            mag = (acc_two > TWO_LIMIT) ? int'(TWO_LIMIT) : int'(acc_two);
                            if (neg_cur) begin
                                tgt_two = 12'(int'(HOME_TWO) - int'(TWO_STEP) * mag);
                            end else begin
                                tgt_two = 12'(int'(HOME_TWO) + int'(TWO_STEP) * mag);
                            end
                            n_applied++;
                        end
                        phase = PH_IDLE;
                        clear_frame();
                    end
                end
            end
            OP_TICK: begin
                cmp_one = slew_toward(cmp_one, tgt_one);
                cmp_two = slew_toward(cmp_two, tgt_two);
                pair.pwm_one = cmp_one;
                pair.pwm_two = cmp_two;
                pwm_due.push_back(pair);
            end
            OP_HOME_ONE: tgt_one = HOME_ONE;
            default:     tgt_two = HOME_TWO;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic void push_cmd(logic [1:0] op, logic [7:0] ch, bit hold = 1'b0,
                                     bit ignored = 1'b0);
        t_cmd_slot s;
        s.cmd.opcode  = op;
        // byte field is don't-care for non-byte commands, so randomize it
        s.cmd.rx_byte = (op == OP_RX_BYTE) ? ch : 8'($urandom);
        s.gap  = tx_quiet ? 0 : $urandom_range(0, 16);
        s.hold = hold;
        cmd_backlog.push_back(s);
        if (!ignored) n_queued++;
        if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) push_cmd(OP_RX_BYTE, s[k]);
    endfunction

    function automatic logic [1:0] pick_event();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? OP_TICK : (r == 1) ? OP_HOME_ONE : OP_HOME_TWO;
    endfunction

    // Character inside a number: mostly digits, a minus now and then (more often leading), rarely any byte
    function automatic logic [7:0] num_char(bit lead);
        int r;
        r = $urandom_range(0, 15);
        if (lead && r < 4) return CH_MINUS;
        if (r == 4) return CH_MINUS;
        if (r == 5) return 8'($urandom);
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Filler biased toward the characters the parser cares about
    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 7))
            0:       return CH_END;
            1:       return CH_COMMA;
            2:       return CH_MINUS;
            3:       return CH_ZERO + 8'($urandom_range(0, 9));
            4:       return CH_START;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] body[$];
        logic [7:0] ch;
        int         pick;
        int         len_one;
        int         len_two;
        bit         hold_done;

        phase   = PH_IDLE;
        clear_frame();
        tgt_one = HOME_ONE;
        tgt_two = HOME_TWO;
        cmp_one = CMP_ONE_RST;
        cmp_two = CMP_TWO_RST;

        // Directed: idle noise, both clamps, home events, "-0" with 'e' in
        // number one and ',' in number two, saturation, missing terminator.
        push_cmd(OP_RX_BYTE, 8'hff, 1'b0, 1'b1);
        push_text("s200,-95e");
        push_cmd(OP_TICK, 8'h00);
        push_cmd(OP_HOME_ONE, 8'h00);
        push_cmd(OP_HOME_TWO, 8'h00);
        push_cmd(OP_TICK, 8'h00, 1'b1);
        push_text("s-0e,9,9e");
        push_text("s99999,1e");
        push_text("s12,34567");
        push_cmd(OP_TICK, 8'h00);

        // Random: framed commands with random content, tick runs, home events, noise
        hold_done = 1'b0;
        while (n_queued < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                body.delete();
                if ($urandom_range(0, 3) != 0) begin
                    len_one = $urandom_range(0, 5);
                    len_two = $urandom_range(0, 6 - len_one);
                    for (int k = 0; k < len_one; k++) body.push_back(num_char(k == 0));
                    body.push_back(CH_COMMA);
                    for (int k = 0; k < len_two; k++) body.push_back(num_char(k == 0));
                    if ($urandom_range(0, 9) != 0) body.push_back(CH_END);
                end
                while (body.size() < FRAME_LEN) body.push_back(junk_char());
                push_cmd(OP_RX_BYTE, CH_START);
                foreach (body[k]) begin
                    // ticks and home events may land inside a frame
                    if ($urandom_range(0, 11) == 0) push_cmd(pick_event(), 8'h00);
                    push_cmd(OP_RX_BYTE, body[k]);
                end
                n_frames++;
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 12)) push_cmd(OP_TICK, 8'h00);
            end else if (pick < 75) begin
                // long run so compare values settle on their targets
                repeat ($urandom_range(30, 70)) push_cmd(OP_TICK, 8'h00);
            end else if (pick < 87) begin
                push_cmd($urandom_range(0, 1) ? OP_HOME_ONE : OP_HOME_TWO, 8'h00);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    ch = 8'($urandom);
                    if (ch == CH_START) ch = 8'h00;
                    // harmless outside a frame; inside one it is real data
                    push_cmd(OP_RX_BYTE, ch, 1'b0, phase == PH_IDLE);
                end
            end
            if (!hold_done && n_queued > ITEM_TARGET / 2) begin
                push_cmd(OP_TICK, 8'h00, 1'b1);
                hold_done = 1'b1;
            end
        end

        // Model starts from the reset state for checking.
        phase   = PH_IDLE;
        clear_frame();
        tgt_one = HOME_ONE;
        tgt_two = HOME_TWO;
        cmp_one = CMP_ONE_RST;
        cmp_two = CMP_TWO_RST;

        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || in_valid || pwm_due.size() != 0);
        repeat (10) @(negedge i_clk);

        if (pwm_due.size() != 0) begin
            $display("%0t: %0d compare updates never arrived", $time, pwm_due.size());
            n_errors++;
        end
        $display("Ran %0d commands with %0d frames, %0d of them updating targets;",
                 n_accepted, n_frames, n_applied);
        $display("checked %0d compare pairs, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: offers the backlog head after its gap (and, for hold, once no result is owed); holds valid until taken
    // ------------------------------------------------------------------------
    bit gap_armed;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            gap_armed = 1'b0;
            gap_left  = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                servo_step(in_data);
                n_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (cmd_backlog.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    if (!gap_armed) begin
                        gap_left  = cmd_backlog[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                        in_valid <= 1'b0;
                    end else if (cmd_backlog[0].hold && pwm_due.size() != 0) begin
                        in_valid <= 1'b0;
                    end else begin
                        in_data   <= cmd_backlog[0].cmd;
                        in_valid  <= 1'b1;
                        void'(cmd_backlog.pop_front());
                        gap_armed = 1'b0;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random stall after every result, compare in order
    // ------------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        t_pwm want;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pwm_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none actual %0d/%0d",
                                 $time, o_out_data.pwm_one, o_out_data.pwm_two);
                end else begin
                    want = pwm_due.pop_front();
                    n_checked++;
                    if (o_out_data.pwm_one !== want.pwm_one) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: pwm_one expected %0d actual %0d",
                                     $time, want.pwm_one, o_out_data.pwm_one);
                    end
                    if (o_out_data.pwm_two !== want.pwm_two) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: pwm_two expected %0d actual %0d",
                                     $time, want.pwm_two, o_out_data.pwm_two);
                    end
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 59) == 0) rx_quiet = !rx_quiet;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

endmodule

[files.f]
design/scps_pkg.sv
design/scps_parser.sv
design/scps_slew.sv
design/servo_command_parser_slew.sv
bench/servo_command_parser_slew_tb.sv
